FILE: hdl/ork_pkg.sv
// Shared types and constants for the fixed-point ODE integrator.
// Used by the interfaces, the configuration block, the sequencer and the datapath.
`timescale 1ns / 1ps

package ork_pkg;

  localparam int STEP_CNT_W = 10;
  localparam int VAL_W      = 32;
  localparam int H_W        = 20;
  localparam int METHOD_W   = 2;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 35;
  localparam int PROD_W     = H_W + 1 + VAL_W;

  localparam logic [METHOD_W-1:0] METH_EULER = 2'd0;
  localparam logic [METHOD_W-1:0] METH_HEUN  = 2'd1;

  localparam logic [METHOD_W-1:0] RST_METHOD    = 2'd2;
  localparam logic [H_W-1:0]      RST_STEP_SIZE = 20'd6554;
  localparam logic [VAL_W-1:0]    RST_INITIAL_Y = 32'd6554;

  // Digit-serial divide by six, one byte of the dividend per cycle.
  localparam int DIV_W       = 40;
  localparam int DIG_W       = 8;
  localparam int DIV_DIGITS  = DIV_W / DIG_W;
  localparam int DIV_CNT_W   = 3;
  localparam int REM_W       = 3;
  localparam int V_W         = REM_W + DIG_W;
  localparam int RECIP_W     = 10;
  localparam int RECIP_SH    = 12;
  localparam logic [RECIP_W-1:0] RECIP_6 = 10'd683;
  localparam logic [V_W-1:0]     DIVISOR = 11'd6;
  // Bias of six times 2^31 makes the dividend positive; plus three for rounding.
  localparam logic [DIV_W-1:0]   DIV_OFFSET = 40'd12884901891;
  localparam logic [DIV_W-1:0]   Q_BIAS     = 40'd2147483648;

  typedef enum logic [1:0] {
    REG_METHOD    = 2'd0,
    REG_STEP_SIZE = 2'd1,
    REG_INITIAL_Y = 2'd2,
    REG_SPARE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [METHOD_W-1:0] method;
    logic [H_W-1:0]      step_size;
    logic [VAL_W-1:0]    initial_y;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_START,
    OP_SLOPE1,
    OP_MUL,
    OP_TRIAL,
    OP_KSLOPE,
    OP_DIVLD,
    OP_AVG,
    OP_YMUL,
    OP_YADD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mid;
  } dp_ctrl_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_MUL,
    ST_TRIAL,
    ST_KSLOPE,
    ST_DIVLD,
    ST_DIV,
    ST_AVG,
    ST_YMUL,
    ST_YADD,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    KS_2,
    KS_3,
    KS_4
  } kstage_t;

  function automatic logic [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic [VAL_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic sat32_hit(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

FILE: hdl/ork_if.sv
// Stream interfaces for the integrator's command and result channels.
// Depends on ork_pkg for the payload widths.
`timescale 1ns / 1ps

interface ork_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [ork_pkg::STEP_CNT_W-1:0]  step_count;

  modport source(output valid, output step_count, input ready);
  modport sink(input valid, input step_count, output ready);
endinterface

interface ork_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [ork_pkg::VAL_W-1:0] final_y;
  logic                            overflow;

  modport source(output valid, output final_y, output overflow, input ready);
  modport sink(input valid, input final_y, input overflow, output ready);
endinterface

FILE: hdl/ode_runge_kutta_integrator.sv
// Fixed-point integrator of dy/dx = x + y by Euler, Heun or fourth-order Runge-Kutta.
// Each step runs on one shared multiplier; the fourth-order step also runs a byte-serial
// divide by six. The block works on one item at a time.
// A new item is taken while the previous result waits in the output register.
// Synchronous reset restores the configuration defaults and empties the output.
`timescale 1ns / 1ps

module ode_runge_kutta_integrator #(
  parameter int MAX_STEPS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ork_pkg::ADDR_W-1:0] paddr,
  input  logic [ork_pkg::DATA_W-1:0] pwdata,
  output logic [ork_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  ork_cmd_if.sink                    cmd,
  ork_res_if.source                  res
);

  ork_pkg::cfg_t             cfg;
  ork_pkg::dp_ctrl_t         ctl;
  ork_pkg::dp_stat_t         stat;
  logic [ork_pkg::VAL_W-1:0] y;
  logic                      ovf;

  ork_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ork_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .ctl  (ctl),
    .stat (stat),
    .y    (y),
    .ovf  (ovf)
  );

  ork_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .res    (res),
    .method (cfg.method),
    .ctl    (ctl),
    .stat   (stat),
    .y      (y),
    .ovf    (ovf)
  );

endmodule

FILE: hdl/ork_cfg.sv
// Configuration registers behind an APB-style write/read port.
// Depends on ork_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module ork_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ork_pkg::ADDR_W-1:0] paddr,
  input  logic [ork_pkg::DATA_W-1:0] pwdata,
  output logic [ork_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ork_pkg::cfg_t              cfg
);

  ork_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = ork_pkg::reg_idx_t'(paddr[ork_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method    <= ork_pkg::RST_METHOD;
      cfg.step_size <= ork_pkg::RST_STEP_SIZE;
      cfg.initial_y <= ork_pkg::RST_INITIAL_Y;
    end else if (wr) begin
      unique case (idx)
        ork_pkg::REG_METHOD:    cfg.method    <= pwdata[ork_pkg::METHOD_W-1:0];
        ork_pkg::REG_STEP_SIZE: cfg.step_size <= pwdata[ork_pkg::H_W-1:0];
        ork_pkg::REG_INITIAL_Y: cfg.initial_y <= pwdata[ork_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ork_pkg::REG_METHOD:    prdata = ork_pkg::DATA_W'(cfg.method);
      ork_pkg::REG_STEP_SIZE: prdata = ork_pkg::DATA_W'(cfg.step_size);
      ork_pkg::REG_INITIAL_Y: prdata = ork_pkg::DATA_W'(cfg.initial_y);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: hdl/ork_div6.sv
// Digit-serial floor division of a positive 40-bit value by six, one byte per cycle.
// Depends on ork_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps

module ork_div6 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ork_pkg::DIV_W-1:0] dividend,
  output logic [ork_pkg::DIV_W-1:0] quotient,
  output logic                      done
);

  logic                          busy;
  logic [ork_pkg::DIV_CNT_W-1:0] cnt;
  logic [ork_pkg::DIV_W-1:0]     dvd;
  logic [ork_pkg::REM_W-1:0]     rem;
  logic [ork_pkg::V_W-1:0]       v;
  logic [ork_pkg::V_W+ork_pkg::RECIP_W-1:0] vmul;
  logic [ork_pkg::DIG_W-1:0]     qd;
  logic [ork_pkg::V_W-1:0]       back;

  // Each partial value is below 1536, where the reciprocal product is exact.
  assign v    = {rem, dvd[ork_pkg::DIV_W-1 -: ork_pkg::DIG_W]};
  assign vmul = (ork_pkg::V_W+ork_pkg::RECIP_W)'(v) *
                (ork_pkg::V_W+ork_pkg::RECIP_W)'(ork_pkg::RECIP_6);
  assign qd   = vmul[ork_pkg::RECIP_SH +: ork_pkg::DIG_W];
  assign back = ork_pkg::V_W'(qd) * ork_pkg::DIVISOR;
  assign done = busy && (cnt == ork_pkg::DIV_CNT_W'(ork_pkg::DIV_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd      <= {dvd[ork_pkg::DIV_W-ork_pkg::DIG_W-1:0], ork_pkg::DIG_W'(0)};
      rem      <= ork_pkg::REM_W'(v - back);
      quotient <= {quotient[ork_pkg::DIV_W-ork_pkg::DIG_W-1:0], qd};
    end
  end

endmodule

FILE: hdl/ork_dp.sv
// Integrator datapath: state registers, the shared step-size multiplier with
// rounding and saturation, the slope accumulator and the divide-by-six unit.
// Depends on ork_pkg and ork_div6.
`timescale 1ns / 1ps

module ork_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ork_pkg::cfg_t             cfg,
  input  ork_pkg::dp_ctrl_t         ctl,
  output ork_pkg::dp_stat_t         stat,
  output logic [ork_pkg::VAL_W-1:0] y,
  output logic                      ovf
);

  localparam logic signed [63:0] HALF_LO = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF_HI = 64'sd1 <<< FRAC_BITS;

  logic [ork_pkg::VAL_W-1:0]        x, yt, k, xm, xh, avg;
  logic signed [ork_pkg::ACC_W-1:0] acc;
  logic signed [ork_pkg::PROD_W-1:0] prod;

  logic signed [ork_pkg::H_W:0]     hs;
  logic signed [ork_pkg::VAL_W-1:0] opnd;
  logic signed [63:0] x64, y64, xsel64, p64, rnd, h64, hh64;
  logic signed [63:0] s_slope1, s_xm, s_xh, s_trial, s_kslope, s_avg;
  logic [ork_pkg::VAL_W-1:0]        knew;
  logic signed [63:0] kw;
  logic [ork_pkg::DIV_W-1:0]        quotient;
  logic                             div_done;

  ork_div6 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.op == ork_pkg::OP_DIVLD),
    .dividend (ork_pkg::DIV_W'(acc) + ork_pkg::DIV_OFFSET),
    .quotient (quotient),
    .done     (div_done)
  );

  assign stat.div_done = div_done;

  assign hs     = $signed({1'b0, cfg.step_size});
  assign opnd   = (ctl.op == ork_pkg::OP_YMUL) ? $signed(avg) : $signed(k);
  assign x64    = 64'($signed(x));
  assign y64    = 64'($signed(y));
  assign h64    = 64'(hs);
  assign hh64   = (h64 + 64'sd1) >>> 1;
  assign p64    = 64'(prod);
  assign rnd    = ctl.mid ? ((p64 + HALF_HI) >>> (FRAC_BITS + 1))
                          : ((p64 + HALF_LO) >>> FRAC_BITS);
  assign xsel64 = ctl.mid ? 64'($signed(xm)) : 64'($signed(xh));

  assign s_slope1 = x64 + y64;
  assign s_xm     = x64 + hh64;
  assign s_xh     = x64 + h64;
  assign s_trial  = y64 + rnd;
  assign s_kslope = xsel64 + 64'($signed(yt));
  assign knew     = ork_pkg::sat32(s_kslope);
  assign kw       = ctl.mid ? (64'($signed(knew)) <<< 1) : 64'($signed(knew));

  always_comb begin
    if (cfg.method == ork_pkg::METH_EULER) begin
      s_avg = 64'(acc);
    end else if (cfg.method == ork_pkg::METH_HEUN) begin
      s_avg = (64'(acc) + 64'sd1) >>> 1;
    end else begin
      s_avg = $signed(64'(quotient) - 64'(ork_pkg::Q_BIAS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else begin
      unique case (ctl.op)
        ork_pkg::OP_START:  ovf <= 1'b0;
        ork_pkg::OP_SLOPE1: ovf <= ovf | ork_pkg::sat32_hit(s_slope1)
                                       | ork_pkg::sat32_hit(s_xh);
        ork_pkg::OP_TRIAL:  ovf <= ovf | ork_pkg::sat32_hit(s_trial);
        ork_pkg::OP_KSLOPE: ovf <= ovf | ork_pkg::sat32_hit(s_kslope);
        ork_pkg::OP_AVG:    ovf <= ovf | ork_pkg::sat32_hit(s_avg);
        ork_pkg::OP_YADD:   ovf <= ovf | ork_pkg::sat32_hit(s_trial);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ork_pkg::OP_START: begin
        x <= '0;
        y <= cfg.initial_y;
      end
      ork_pkg::OP_SLOPE1: begin
        k   <= ork_pkg::sat32(s_slope1);
        acc <= ork_pkg::ACC_W'($signed(ork_pkg::sat32(s_slope1)));
        xm  <= ork_pkg::sat32(s_xm);
        xh  <= ork_pkg::sat32(s_xh);
      end
      ork_pkg::OP_MUL, ork_pkg::OP_YMUL: begin
        prod <= hs * opnd;
      end
      ork_pkg::OP_TRIAL: begin
        yt <= ork_pkg::sat32(s_trial);
      end
      ork_pkg::OP_KSLOPE: begin
        k   <= knew;
        acc <= acc + ork_pkg::ACC_W'(kw);
      end
      ork_pkg::OP_AVG: begin
        avg <= ork_pkg::sat32(s_avg);
      end
      ork_pkg::OP_YADD: begin
        y <= ork_pkg::sat32(s_trial);
        x <= xh;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/ork_ctrl.sv
// Sequencer for the integrator: walks each step through the shared datapath
// and holds the result register on the output channel.
// Depends on ork_pkg and the stream interfaces.
`timescale 1ns / 1ps

module ork_ctrl #(
  parameter int MAX_STEPS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  ork_cmd_if.sink                      cmd,
  ork_res_if.source                    res,
  input  logic [ork_pkg::METHOD_W-1:0] method,
  output ork_pkg::dp_ctrl_t            ctl,
  input  ork_pkg::dp_stat_t            stat,
  input  logic [ork_pkg::VAL_W-1:0]    y,
  input  logic                         ovf
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  ork_pkg::state_t  state, state_next;
  ork_pkg::kstage_t kidx, kidx_next;
  logic [CNT_W-1:0] steps_left, steps_left_next;
  logic [CNT_W-1:0] n_clamped;
  logic [31:0]      sc_ext;
  logic             is_euler, is_heun, is_rk4, load_out;

  assign is_euler  = (method == ork_pkg::METH_EULER);
  assign is_heun   = (method == ork_pkg::METH_HEUN);
  assign is_rk4    = !is_euler && !is_heun;
  assign sc_ext    = 32'(cmd.step_count);
  assign n_clamped = (sc_ext > 32'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : CNT_W'(sc_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ork_pkg::ST_IDLE;
      kidx       <= ork_pkg::KS_2;
      steps_left <= '0;
    end else begin
      state      <= state_next;
      kidx       <= kidx_next;
      steps_left <= steps_left_next;
    end
  end

  always_comb begin
    state_next      = state;
    kidx_next       = kidx;
    steps_left_next = steps_left;
    ctl.op          = ork_pkg::OP_HOLD;
    ctl.mid         = 1'b0;
    cmd.ready       = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      ork_pkg::ST_IDLE: begin
        cmd.ready = !rst;
        if (cmd.valid && !rst) begin
          ctl.op          = ork_pkg::OP_START;
          steps_left_next = n_clamped;
          state_next      = (n_clamped == '0) ? ork_pkg::ST_FIN : ork_pkg::ST_K1;
        end
      end
      ork_pkg::ST_K1: begin
        ctl.op     = ork_pkg::OP_SLOPE1;
        kidx_next  = ork_pkg::KS_2;
        state_next = is_euler ? ork_pkg::ST_AVG : ork_pkg::ST_MUL;
      end
      ork_pkg::ST_MUL: begin
        ctl.op     = ork_pkg::OP_MUL;
        ctl.mid    = is_rk4 && (kidx != ork_pkg::KS_4);
        state_next = ork_pkg::ST_TRIAL;
      end
      ork_pkg::ST_TRIAL: begin
        ctl.op     = ork_pkg::OP_TRIAL;
        ctl.mid    = is_rk4 && (kidx != ork_pkg::KS_4);
        state_next = ork_pkg::ST_KSLOPE;
      end
      ork_pkg::ST_KSLOPE: begin
        ctl.op  = ork_pkg::OP_KSLOPE;
        ctl.mid = is_rk4 && (kidx != ork_pkg::KS_4);
        if (!is_rk4) begin
          state_next = ork_pkg::ST_AVG;
        end else if (kidx == ork_pkg::KS_4) begin
          state_next = ork_pkg::ST_DIVLD;
        end else begin
          kidx_next  = (kidx == ork_pkg::KS_2) ? ork_pkg::KS_3 : ork_pkg::KS_4;
          state_next = ork_pkg::ST_MUL;
        end
      end
      ork_pkg::ST_DIVLD: begin
        ctl.op     = ork_pkg::OP_DIVLD;
        state_next = ork_pkg::ST_DIV;
      end
      ork_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = ork_pkg::ST_AVG;
        end
      end
      ork_pkg::ST_AVG: begin
        ctl.op     = ork_pkg::OP_AVG;
        state_next = ork_pkg::ST_YMUL;
      end
      ork_pkg::ST_YMUL: begin
        ctl.op     = ork_pkg::OP_YMUL;
        state_next = ork_pkg::ST_YADD;
      end
      ork_pkg::ST_YADD: begin
        ctl.op          = ork_pkg::OP_YADD;
        steps_left_next = steps_left - 1'b1;
        state_next      = (steps_left == CNT_W'(1)) ? ork_pkg::ST_FIN : ork_pkg::ST_K1;
      end
      ork_pkg::ST_FIN: begin
        if (!res.valid || res.ready) begin
          load_out   = 1'b1;
          state_next = ork_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ork_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.final_y  <= $signed(y);
      res.overflow <= ovf;
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for ode_runge_kutta_integrator: drives step counts over the
// command stream and register settings over APB, and checks every final y and overflow.
// Depends on ork_pkg, the stream interfaces in ork_if.sv, and the integrator RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [ork_pkg::METHOD_W-1:0] METH_RK4   = 2'd2;
  localparam logic [ork_pkg::METHOD_W-1:0] METH_SPARE = 2'd3;
  localparam logic [ork_pkg::VAL_W-1:0]    Y_MAX      = 32'h7FFF_FFFF;
  localparam logic [ork_pkg::VAL_W-1:0]    Y_MIN      = 32'h8000_0000;
  localparam logic [ork_pkg::H_W-1:0]      H_MAX      = 20'hF_FFFF;

  typedef struct packed {
    logic signed [ork_pkg::VAL_W-1:0] final_y;
    logic                             overflow;
  } ode_result_t;

  typedef struct packed {
    logic [ork_pkg::METHOD_W-1:0]   method;
    logic [ork_pkg::H_W-1:0]        h;
    logic [ork_pkg::VAL_W-1:0]      y0;
    logic [ork_pkg::STEP_CNT_W-1:0] n;
    logic                           typed;
    logic [ork_pkg::VAL_W-1:0]      exp_y;
    logic                           exp_ovf;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ork_pkg::ADDR_W-1:0]   paddr;
  logic [ork_pkg::DATA_W-1:0]   pwdata;
  logic [ork_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  ork_cmd_if cmd_if();
  ork_res_if res_if();

  ode_runge_kutta_integrator dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd(cmd_if),
    .res(res_if)
  );

  logic [ork_pkg::METHOD_W-1:0]     cfg_method = ork_pkg::RST_METHOD;
  logic [ork_pkg::H_W-1:0]          cfg_step   = ork_pkg::RST_STEP_SIZE;
  logic signed [ork_pkg::VAL_W-1:0] cfg_y0     = ork_pkg::RST_INITIAL_Y;

  ode_result_t awaited_results[$];
  logic        hold_typed = 1'b0;
  ode_result_t hold_result;
  logic        clipped;
  logic        quiet = 1'b0;
  logic        calm = 1'b0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_settings = 0;
  stim_row_t   dir_rows[21];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(input longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint h_times(input longint h, input longint k, input int extra);
    longint p;
    int     s;
    s = 16 + extra;
    p = h * k + (64'sd1 << (s - 1));
    return p >>> s;
  endfunction

  function automatic ode_result_t integrate_ode(input logic [ork_pkg::STEP_CNT_W-1:0] n);
    longint      h, hh, x, y, k1, k2, k3, k4, xm, avg, sum;
    ode_result_t r;
    h = longint'({44'd0, cfg_step});
    hh = (h + 1) >>> 1;
    x = 0;
    y = longint'(cfg_y0);
    clipped = 1'b0;
    for (int i = 0; i < int'(n); i++) begin
      k1 = clip(x + y);
      if (cfg_method == ork_pkg::METH_EULER) begin
        avg = k1;
      end else if (cfg_method == ork_pkg::METH_HEUN) begin
        k2 = clip(clip(x + h) + clip(y + h_times(h, k1, 0)));
        avg = clip((k1 + k2 + 1) >>> 1);
      end else begin
        xm = clip(x + hh);
        k2 = clip(xm + clip(y + h_times(h, k1, 1)));
        k3 = clip(xm + clip(y + h_times(h, k2, 1)));
        k4 = clip(clip(x + h) + clip(y + h_times(h, k3, 0)));
        sum = k1 + 2 * k2 + 2 * k3 + k4 + 3;
        avg = sum / 6;
        if (sum % 6 != 0 && sum < 0) begin
          avg = avg - 1;
        end
        avg = clip(avg);
      end
      y = clip(y + h_times(h, avg, 0));
      x = clip(x + h);
    end
    r.final_y = y[ork_pkg::VAL_W-1:0];
    r.overflow = clipped;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result, final_y", res_if.final_y, 0);
        end else begin
          ode_result_t want;
          want = awaited_results.pop_front();
          if (res_if.final_y !== want.final_y) begin
            flag_mismatch("final_y", res_if.final_y, want.final_y);
          end
          if (res_if.overflow !== want.overflow) begin
            flag_mismatch("overflow", res_if.overflow, want.overflow);
          end
          n_checked++;
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        awaited_results.push_back(hold_typed ? hold_result : integrate_ode(cmd_if.step_count));
      end
    end
  end

  initial begin
    int len;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet || calm || $urandom_range(0, 2) != 0) begin
        res_if.ready <= 1'b1;
        len = $urandom_range(1, 16);
      end else begin
        res_if.ready <= 1'b0;
        len = $urandom_range(1, 8);
      end
      repeat (len) @(negedge clk);
    end
  end

  task automatic apb_write(input ork_pkg::reg_idx_t idx,
                           input logic [ork_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(input logic [ork_pkg::METHOD_W-1:0] m,
                               input logic [ork_pkg::H_W-1:0] h,
                               input logic [ork_pkg::VAL_W-1:0] y0);
    drain();
    apb_write(ork_pkg::REG_METHOD, {30'd0, m});
    apb_write(ork_pkg::REG_STEP_SIZE, {12'd0, h});
    apb_write(ork_pkg::REG_INITIAL_Y, y0);
    cfg_method = m;
    cfg_step = h;
    cfg_y0 = y0;
    n_settings++;
  endtask

  task automatic send_item(input logic [ork_pkg::STEP_CNT_W-1:0] n, input logic typed,
                           input ode_result_t want);
    int gap;
    gap = (!quiet && !calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hold_typed = typed;
    hold_result = want;
    cmd_if.valid <= 1'b1;
    cmd_if.step_count <= n;
    do @(posedge clk); while (!cmd_if.ready);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [ork_pkg::H_W-1:0] pick_step();
    unique case ($urandom_range(0, 7))
      0: return '0;
      1: return H_MAX;
      2, 3: return ork_pkg::H_W'($urandom);
      default: return ork_pkg::H_W'($urandom_range(1, 13107));
    endcase
  endfunction

  function automatic logic [ork_pkg::VAL_W-1:0] pick_y0();
    unique case ($urandom_range(0, 7))
      0: return Y_MIN;
      1: return Y_MAX;
      2: return '0;
      3, 4: return $urandom;
      default: return ork_pkg::VAL_W'($urandom_range(0, 1 << 19)) - 32'd262144;
    endcase
  endfunction

  initial begin
    logic [ork_pkg::STEP_CNT_W-1:0] n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_if.valid = 1'b0;
    cmd_if.step_count = '0;
    hold_result = '0;

    dir_rows = '{
      '{METH_RK4,            20'd6554,  32'd6554,    10'd0,    1'b1, 32'd6554,    1'b0},
      '{METH_RK4,            20'd6554,  32'd6554,    10'd1,    1'b0, 32'd0,       1'b0},
      '{METH_RK4,            20'd6554,  32'd6554,    10'd10,   1'b0, 32'd0,       1'b0},
      '{METH_RK4,            20'd6554,  32'd6554,    10'd1023, 1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_EULER, 20'd6554,  32'd6554,    10'd10,   1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_HEUN,  20'd6554,  32'd6554,    10'd10,   1'b0, 32'd0,       1'b0},
      '{METH_SPARE,          20'd6554,  32'd6554,    10'd10,   1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_EULER, 20'd0,     32'd12345,   10'd1023, 1'b1, 32'd12345,   1'b0},
      '{METH_RK4,            20'd0,     -32'sd98765, 10'd5,    1'b1, -32'sd98765, 1'b0},
      '{ork_pkg::METH_HEUN,  20'd0,     Y_MIN,       10'd3,    1'b1, Y_MIN,       1'b0},
      '{ork_pkg::METH_EULER, H_MAX,     Y_MAX,       10'd4,    1'b1, Y_MAX,       1'b1},
      '{ork_pkg::METH_EULER, H_MAX,     Y_MIN,       10'd4,    1'b1, Y_MIN,       1'b1},
      '{METH_RK4,            H_MAX,     Y_MAX,       10'd1023, 1'b1, Y_MAX,       1'b1},
      '{METH_RK4,            H_MAX,     32'd0,       10'd1023, 1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_HEUN,  H_MAX,     -32'sd1,     10'd512,  1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_EULER, 20'd1,     32'd0,       10'd1023, 1'b0, 32'd0,       1'b0},
      '{METH_RK4,            20'd65536, 32'd65536,   10'd20,   1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_HEUN,  20'd32768, -32'sd65536, 10'd100,  1'b0, 32'd0,       1'b0},
      '{ork_pkg::METH_EULER, 20'd6554,  Y_MAX,       10'd0,    1'b1, Y_MAX,       1'b0},
      '{METH_SPARE,          H_MAX,     Y_MIN,       10'd1,    1'b0, 32'd0,       1'b0},
      '{METH_RK4,            20'd13107, -32'sd6554,  10'd37,   1'b0, 32'd0,       1'b0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].method != cfg_method || dir_rows[i].h != cfg_step ||
          dir_rows[i].y0 != cfg_y0) begin
        load_settings(dir_rows[i].method, dir_rows[i].h, dir_rows[i].y0);
      end
      send_item(dir_rows[i].n, dir_rows[i].typed, '{dir_rows[i].exp_y, dir_rows[i].exp_ovf});
    end

    for (int phase = 0; phase < 8; phase++) begin
      load_settings(ork_pkg::METHOD_W'($urandom_range(0, 3)), pick_step(), pick_y0());
      quiet = (phase == 7);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 12; k++) begin
        n = (k == 11) ? ork_pkg::STEP_CNT_W'($urandom_range(256, 1023))
                      : ork_pkg::STEP_CNT_W'($urandom_range(0, 40));
        send_item(n, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("Sent %0d items over %0d register settings and all four method codes.",
             n_sent, n_settings);
    $display("Compared %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
